/* src/rbs_pkg.sv */
// Shared types and constants for the ray versus box slab test.
`default_nettype none
package rbs_pkg;

    localparam int DIR_FRAC_BITS = 30;
    localparam int CMAG_BITS     = 33;  // magnitude of a corner minus origin
    localparam int QUOT_BITS     = 53;  // quotient bits; divisor is at least the epsilon
    localparam int HEAD_BITS     = CMAG_BITS + DIR_FRAC_BITS - QUOT_BITS;
    localparam int DIV_STAGES    = QUOT_BITS;

    localparam logic [31:0] DIR_EPS_RAW = 32'd1074;
    localparam logic [30:0] DIST_MAX    = 31'h7FFF_FFFF;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
    } t_ray;

    typedef struct packed {
        logic        hit;
        logic [30:0] distance;
        logic [1:0]  normal_axis;
        logic        normal_sign;
    } t_hit;

endpackage
`default_nettype wire

/* src/rbs_axis_div.sv */
// Pipelined restoring divider: two dividends over one divisor, one quotient bit per stage.
`default_nettype none
module rbs_axis_div (
    input  logic                                 i_clk,
    input  logic [rbs_pkg::CMAG_BITS-1:0]        i_num_a,
    input  logic [rbs_pkg::CMAG_BITS-1:0]        i_num_b,
    input  logic [31:0]                          i_den,
    output logic [rbs_pkg::QUOT_BITS-1:0]        o_quot_a,
    output logic [rbs_pkg::QUOT_BITS-1:0]        o_quot_b
);

    localparam int QB   = rbs_pkg::QUOT_BITS;
    localparam int CB   = rbs_pkg::CMAG_BITS;
    localparam int HB   = rbs_pkg::HEAD_BITS;
    localparam int FB   = rbs_pkg::DIR_FRAC_BITS;

    logic [31:0]   r_rem_a [QB];
    logic [31:0]   r_rem_b [QB];
    logic [QB-1:0] r_w_a   [QB];
    logic [QB-1:0] r_w_b   [QB];
    logic [31:0]   r_den   [QB-1];

    // w holds the dividend bits still to come on top and quotient bits below
    function automatic logic [31+QB:0] div_step(input logic [31:0] rem,
                                                input logic [QB-1:0] w,
                                                input logic [31:0] den);
        logic [32:0] trial;
        logic [32:0] diff;
        logic        ge;
        trial = {rem, w[QB-1]};
        ge    = (trial >= {1'b0, den});
        diff  = trial - {1'b0, den};
        return {(ge ? diff[31:0] : trial[31:0]), w[QB-2:0], ge};
    endfunction

    // top dividend bits are below the divisor, so they seed the remainder
    logic [31:0]   init_rem_a, init_rem_b;
    logic [QB-1:0] init_w_a, init_w_b;

    assign init_rem_a = {{(32-HB){1'b0}}, i_num_a[CB-1 -: HB]};
    assign init_rem_b = {{(32-HB){1'b0}}, i_num_b[CB-1 -: HB]};
    assign init_w_a   = {i_num_a[CB-HB-1:0], {FB{1'b0}}};
    assign init_w_b   = {i_num_b[CB-HB-1:0], {FB{1'b0}}};

    always_ff @(posedge i_clk) begin
        {r_rem_a[0], r_w_a[0]} <= div_step(init_rem_a, init_w_a, i_den);
        {r_rem_b[0], r_w_b[0]} <= div_step(init_rem_b, init_w_b, i_den);
        r_den[0]               <= i_den;
        for (int g = 1; g < QB; g++) begin
            {r_rem_a[g], r_w_a[g]} <= div_step(r_rem_a[g-1], r_w_a[g-1], r_den[g-1]);
            {r_rem_b[g], r_w_b[g]} <= div_step(r_rem_b[g-1], r_w_b[g-1], r_den[g-1]);
        end
        for (int g = 1; g < QB-1; g++) begin
            r_den[g] <= r_den[g-1];
        end
    end

    assign o_quot_a = r_w_a[QB-1];
    assign o_quot_b = r_w_b[QB-1];

endmodule
`default_nettype wire

/* src/ray_box_slab_intersection.sv */
// Top level: fixed-point ray versus axis-aligned box slab test, fully pipelined.
//
// Usage: drive a ray and box word on i_ray and raise start; the word is taken at
// each rising edge where start is high and busy is low. busy is low at all
// times outside reset, so a new word may enter every cycle.
// Each accepted word yields exactly one result word on o_res, flagged by
// o_done for one cycle, in input order. The pipeline holds the input and setup
// stages, the per-axis dividers, which retire one quotient bit per stage
// (53 stages), and three compare/narrowing stages.
// Throughput: one word per cycle.
// Reset (synchronous, active low) drops every word in flight; busy is high
// while reset is held. The receiver cannot stall: o_done is a strobe and the
// result must be captured in that cycle.
// Result: hit, entry distance (unsigned, saturated), entry face axis (3 on a
// miss, when the origin is inside or when the entry lies behind it) and face sign.
`default_nettype none
module ray_box_slab_intersection (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rbs_pkg::t_ray i_ray,
    output logic          o_done,
    output rbs_pkg::t_hit o_res
);

    localparam int QB  = rbs_pkg::QUOT_BITS;
    localparam int DS  = rbs_pkg::DIV_STAGES;
    localparam int LAT = DS + 5;

    typedef struct packed {
        logic [2:0] skip;   // near-zero direction on this axis
        logic [2:0] bad;    // near-zero and origin outside the slab
        logic [2:0] neg_a;
        logic [2:0] neg_b;
    } t_side;

    assign busy = ~i_rst_n;

    // input register
    rbs_pkg::t_ray r_in;
    logic          r_v_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in <= 1'b0;
        end else begin
            r_v_in <= start;
        end
        r_in <= i_ray;
    end

    // setup: differences, magnitudes, signs
    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    logic signed [31:0] bmn [3];
    logic signed [31:0] bmx [3];

    assign org[0] = r_in.origin_x;
    assign org[1] = r_in.origin_y;
    assign org[2] = r_in.origin_z;
    assign dir[0] = r_in.dir_x;
    assign dir[1] = r_in.dir_y;
    assign dir[2] = r_in.dir_z;
    assign bmn[0] = r_in.box_min_x;
    assign bmn[1] = r_in.box_min_y;
    assign bmn[2] = r_in.box_min_z;
    assign bmx[0] = r_in.box_max_x;
    assign bmx[1] = r_in.box_max_y;
    assign bmx[2] = r_in.box_max_z;

    logic [32:0] n_num_a [3];
    logic [32:0] n_num_b [3];
    logic [31:0] n_den   [3];
    t_side       n_side;

    always_comb begin
        logic signed [32:0] dx;
        logic signed [32:0] adx;
        logic signed [32:0] da;
        logic signed [32:0] db;
        logic signed [32:0] ma;
        logic signed [32:0] mb;
        n_side = '0;
        for (int i = 0; i < 3; i++) begin
            dx  = {dir[i][31], dir[i]};
            adx = dx[32] ? -dx : dx;
            da  = {bmn[i][31], bmn[i]} - {org[i][31], org[i]};
            db  = {bmx[i][31], bmx[i]} - {org[i][31], org[i]};
            ma  = da[32] ? -da : da;
            mb  = db[32] ? -db : db;
            n_num_a[i]      = ma;
            n_num_b[i]      = mb;
            n_den[i]        = adx[31:0];
            n_side.skip[i]  = (adx[31:0] < rbs_pkg::DIR_EPS_RAW);
            n_side.bad[i]   = n_side.skip[i] && ((org[i] < bmn[i]) || (org[i] > bmx[i]));
            n_side.neg_a[i] = da[32] ^ dir[i][31];
            n_side.neg_b[i] = db[32] ^ dir[i][31];
        end
    end

    logic [32:0] r_num_a [3];
    logic [32:0] r_num_b [3];
    logic [31:0] r_den   [3];
    t_side       r_side  [DS+1];
    logic        r_vp    [DS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DS; k++) begin
                r_vp[k] <= 1'b0;
            end
        end else begin
            r_vp[0] <= r_v_in;
            for (int k = 1; k <= DS; k++) begin
                r_vp[k] <= r_vp[k-1];
            end
        end
        r_side[0] <= n_side;
        for (int k = 1; k <= DS; k++) begin
            r_side[k] <= r_side[k-1];
        end
        for (int i = 0; i < 3; i++) begin
            r_num_a[i] <= n_num_a[i];
            r_num_b[i] <= n_num_b[i];
            r_den[i]   <= n_den[i];
        end
    end

    logic [QB-1:0] quot_a [3];
    logic [QB-1:0] quot_b [3];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbs_axis_div u_div (
            .i_clk    (i_clk),
            .i_num_a  (r_num_a[a]),
            .i_num_b  (r_num_b[a]),
            .i_den    (r_den[a]),
            .o_quot_a (quot_a[a]),
            .o_quot_b (quot_b[a])
        );
    end

    // order, face sign and clamp per axis
    logic [30:0]        n_ent [3];
    logic signed [31:0] n_ext [3];
    logic [2:0]         n_fs;

    always_comb begin
        logic signed [QB:0] t1;
        logic signed [QB:0] t2;
        logic signed [QB:0] tl;
        logic signed [QB:0] th;
        logic signed [QB:0] tmax;
        tmax = {{(QB-30){1'b0}}, rbs_pkg::DIST_MAX};
        n_fs = '0;
        for (int i = 0; i < 3; i++) begin
            t1 = r_side[DS].neg_a[i] ? -{1'b0, quot_a[i]} : {1'b0, quot_a[i]};
            t2 = r_side[DS].neg_b[i] ? -{1'b0, quot_b[i]} : {1'b0, quot_b[i]};
            n_fs[i] = !(t1 < t2);
            tl = (t1 > t2) ? t2 : t1;
            th = (t1 > t2) ? t1 : t2;
            // a negative entry never beats zero; a negative exit always misses
            if (tl < 0) begin
                n_ent[i] = '0;
            end else if (tl > tmax) begin
                n_ent[i] = rbs_pkg::DIST_MAX;
            end else begin
                n_ent[i] = tl[30:0];
            end
            if (th < 0) begin
                n_ext[i] = -32'sd1;
            end else if (th > tmax) begin
                n_ext[i] = {1'b0, rbs_pkg::DIST_MAX};
            end else begin
                n_ext[i] = {1'b0, th[30:0]};
            end
        end
    end

    logic [30:0]        r_ent [3];
    logic signed [31:0] r_ext [3];
    logic [2:0]         r_fs;
    logic [2:0]         r_skip;
    logic [2:0]         r_bad;
    logic               r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_vp[DS];
        end
        for (int i = 0; i < 3; i++) begin
            r_ent[i] <= n_ent[i];
            r_ext[i] <= n_ext[i];
        end
        r_fs   <= n_fs;
        r_skip <= r_side[DS].skip;
        r_bad  <= r_side[DS].bad;
    end

    // narrowing over x and y
    logic [30:0]        n_near2;
    logic signed [31:0] n_far2;
    logic [1:0]         n_axis2;
    logic               n_sign2;

    always_comb begin
        n_near2 = '0;
        n_far2  = {1'b0, rbs_pkg::DIST_MAX};
        n_axis2 = rbs_pkg::AXIS_NONE;
        n_sign2 = 1'b0;
        if (!r_skip[0]) begin
            if (r_ent[0] > n_near2) begin
                n_near2 = r_ent[0];
                n_axis2 = rbs_pkg::AXIS_X;
                n_sign2 = r_fs[0];
            end
            if (r_ext[0] < n_far2) begin
                n_far2 = r_ext[0];
            end
        end
        if (!r_skip[1]) begin
            if (r_ent[1] > n_near2) begin
                n_near2 = r_ent[1];
                n_axis2 = rbs_pkg::AXIS_Y;
                n_sign2 = r_fs[1];
            end
            if (r_ext[1] < n_far2) begin
                n_far2 = r_ext[1];
            end
        end
    end

    logic [30:0]        r_near2;
    logic signed [31:0] r_far2;
    logic [1:0]         r_axis2;
    logic               r_sign2;
    logic [30:0]        r_ent_z;
    logic signed [31:0] r_ext_z;
    logic               r_fs_z;
    logic               r_skip_z;
    logic               r_bad_any;
    logic               r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_near2   <= n_near2;
        r_far2    <= n_far2;
        r_axis2   <= n_axis2;
        r_sign2   <= n_sign2;
        r_ent_z   <= r_ent[2];
        r_ext_z   <= r_ext[2];
        r_fs_z    <= r_fs[2];
        r_skip_z  <= r_skip[2];
        r_bad_any <= |r_bad;
    end

    // z axis and final word; a miss at any step persists to the end
    rbs_pkg::t_hit n_res;

    always_comb begin
        logic [30:0]        nr;
        logic signed [31:0] fr;
        logic [1:0]         ax;
        logic               sg;
        nr = r_near2;
        fr = r_far2;
        ax = r_axis2;
        sg = r_sign2;
        if (!r_skip_z) begin
            if (r_ent_z > nr) begin
                nr = r_ent_z;
                ax = rbs_pkg::AXIS_Z;
                sg = r_fs_z;
            end
            if (r_ext_z < fr) begin
                fr = r_ext_z;
            end
        end
        if (r_bad_any || ($signed({1'b0, nr}) > fr)) begin
            n_res.hit         = 1'b0;
            n_res.distance    = '0;
            n_res.normal_axis = rbs_pkg::AXIS_NONE;
            n_res.normal_sign = 1'b0;
        end else begin
            n_res.hit         = 1'b1;
            n_res.distance    = nr;
            n_res.normal_axis = ax;
            n_res.normal_sign = sg;
        end
    end

    rbs_pkg::t_hit r_res;
    logic          r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v2;
        end
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

`ifndef SYNTHESIS
    a_done_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result word without an accepted input word");

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_res.hit) |-> (o_res.distance == '0 &&
        o_res.normal_axis == rbs_pkg::AXIS_NONE && !o_res.normal_sign))
        else $error("miss word carries nonzero fields");

    a_inside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.normal_axis == rbs_pkg::AXIS_NONE) |->
        (o_res.distance == '0 && !o_res.normal_sign))
        else $error("no entry face but nonzero distance or sign");
`endif

endmodule
`default_nettype wire

/* tb/ray_box_slab_intersection_tb.sv */
// Testbench for the ray versus box slab test: directed and random rays checked in order.
`timescale 1ns / 100ps
`default_nettype none
module ray_box_slab_intersection_tb;

    localparam int LATENCY   = 57;
    localparam int CYCLE_CAP = 400000;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    rbs_pkg::t_ray  i_ray = '0;
    logic           o_done;
    rbs_pkg::t_hit  o_res;

    rbs_pkg::t_hit  hits_pending[$];
    int    n_errors = 0;
    int    n_sent = 0;
    int    n_hits = 0;
    int    n_checked = 0;
    int    cycle_count = 0;

    ray_box_slab_intersection i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_ray  (i_ray),
        .o_done (o_done),
        .o_res  (o_res)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // (num << 30) / den, truncated toward zero
    function automatic longint slab_quot(longint num, longint den);
        logic [63:0] un;
        logic [63:0] ud;
        logic [63:0] q;
        bit          neg;
        neg = (num < 0) != (den < 0);
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        q = (un << rbs_pkg::DIR_FRAC_BITS) / ud;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic rbs_pkg::t_hit slab_hit(rbs_pkg::t_ray r);
        longint o[3], d[3], lo[3], hi[3];
        longint t_near, t_far, t1, t2, ad, tmp;
        logic [1:0]    axis;
        logic          sgn;
        rbs_pkg::t_hit res;
        o  = '{r.origin_x, r.origin_y, r.origin_z};
        d  = '{r.dir_x, r.dir_y, r.dir_z};
        lo = '{r.box_min_x, r.box_min_y, r.box_min_z};
        hi = '{r.box_max_x, r.box_max_y, r.box_max_z};
        t_near = 0;
        t_far = rbs_pkg::DIST_MAX;
        axis = rbs_pkg::AXIS_NONE;
        sgn = 1'b0;
        res = '{hit: 1'b0, distance: '0, normal_axis: rbs_pkg::AXIS_NONE, normal_sign: 1'b0};
        for (int i = 0; i < 3; i++) begin
            ad = (d[i] < 0) ? -d[i] : d[i];
            if (ad < longint'(rbs_pkg::DIR_EPS_RAW)) begin
                if (o[i] < lo[i] || o[i] > hi[i]) begin
                    res.normal_sign = 1'b0;
                    return res;
                end
            end else begin
                t1 = slab_quot(lo[i] - o[i], d[i]);
                t2 = slab_quot(hi[i] - o[i], d[i]);
                // face sign is taken before clamping
                sgn = (t1 < t2) ? 1'b0 : 1'b1;
                if (t1 > t2) begin
                    tmp = t1; t1 = t2; t2 = tmp;
                end
                if (t1 > longint'(rbs_pkg::DIST_MAX)) t1 = rbs_pkg::DIST_MAX;
                if (t2 > longint'(rbs_pkg::DIST_MAX)) t2 = rbs_pkg::DIST_MAX;
                if (t1 > t_near) begin
                    t_near = t1;
                    axis = i[1:0];
                    res.normal_sign = sgn;
                end
                if (t2 < t_far) t_far = t2;
                if (t_near > t_far) begin
                    res.normal_sign = 1'b0;
                    return res;
                end
            end
        end
        res.hit = 1'b1;
        res.distance = t_near[30:0];
        res.normal_axis = axis;
        return res;
    endfunction

    // result checker: the receiver never stalls, so every strobe is taken
    always @(posedge i_clk) begin
        rbs_pkg::t_hit want;
        if (i_rst_n && o_done) begin
            if (hits_pending.size() == 0) begin
                $error("result word with nothing expected");
                n_errors++;
            end else begin
                want = hits_pending.pop_front();
                n_checked++;
                if (o_res.hit !== want.hit) begin
                    $error("hit: expected %0d got %0d", want.hit, o_res.hit);
                    n_errors++;
                end
                if (o_res.distance !== want.distance) begin
                    $error("distance: expected %0d got %0d", want.distance, o_res.distance);
                    n_errors++;
                end
                if (o_res.normal_axis !== want.normal_axis) begin
                    $error("normal_axis: expected %0d got %0d",
                           want.normal_axis, o_res.normal_axis);
                    n_errors++;
                end
                if (o_res.normal_sign !== want.normal_sign) begin
                    $error("normal_sign: expected %0d got %0d",
                           want.normal_sign, o_res.normal_sign);
                    n_errors++;
                end
            end
        end
    end

    // gap: idle cycles before this word; start stays high across back-to-back words
    task automatic send_ray(rbs_pkg::t_ray r, int gap);
        rbs_pkg::t_hit want;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_ray <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        want = slab_hit(r);
        hits_pending.push_back(want);
        n_sent++;
        if (want.hit) n_hits++;
    endtask

    function automatic logic signed [31:0] rand_dir();
        case ($urandom_range(0, 7))
            0: return 32'sd0;
            1: return $signed($urandom_range(0, 2147)) - 32'sd1073;
            2: return 32'sh4000_0000;
            3: return -32'sh4000_0000;
            4: return $urandom();
            default: return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coord(int scale);
        if (scale == 0) return $urandom();
        return $signed($urandom_range(0, 2 * scale)) - scale;
    endfunction

    function automatic rbs_pkg::t_ray make_ray(int scale);
        rbs_pkg::t_ray r;
        logic signed [31:0] a, b;
        r.origin_x = rand_coord(scale);
        r.origin_y = rand_coord(scale);
        r.origin_z = rand_coord(scale);
        r.dir_x = rand_dir();
        r.dir_y = rand_dir();
        r.dir_z = rand_dir();
        a = rand_coord(scale); b = rand_coord(scale);
        // mostly ordered corners, sometimes inverted
        if ($urandom_range(0, 9) != 0 && a > b) begin
            r.box_min_x = b; r.box_max_x = a;
        end else begin
            r.box_min_x = a; r.box_max_x = b;
        end
        a = rand_coord(scale); b = rand_coord(scale);
        if ($urandom_range(0, 9) != 0 && a > b) begin
            r.box_min_y = b; r.box_max_y = a;
        end else begin
            r.box_min_y = a; r.box_max_y = b;
        end
        a = rand_coord(scale); b = rand_coord(scale);
        if ($urandom_range(0, 9) != 0 && a > b) begin
            r.box_min_z = b; r.box_max_z = a;
        end else begin
            r.box_min_z = a; r.box_max_z = b;
        end
        return r;
    endfunction

    function automatic rbs_pkg::t_ray unit_box_ray(logic signed [31:0] ox,
                                                   logic signed [31:0] dx,
                                                   logic signed [31:0] dy,
                                                   logic signed [31:0] dz);
        rbs_pkg::t_ray r;
        r.origin_x = ox; r.origin_y = 32'sh0000_8000; r.origin_z = 32'sh0000_8000;
        r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
        r.box_min_x = 32'sh0001_0000; r.box_min_y = '0; r.box_min_z = '0;
        r.box_max_x = 32'sh0002_0000; r.box_max_y = 32'sh0001_0000;
        r.box_max_z = 32'sh0001_0000;
        return r;
    endfunction

    task automatic test_directed();
        rbs_pkg::t_ray r;
        // hit through -x face, from +x side, origin inside, behind, miss
        send_ray(unit_box_ray(32'sh0, 32'sh4000_0000, 0, 0), 0);
        send_ray(unit_box_ray(32'sh0003_0000, -32'sh4000_0000, 0, 0), 0);
        send_ray(unit_box_ray(32'sh0001_8000, 32'sh4000_0000, 0, 0), 1);
        send_ray(unit_box_ray(32'sh0003_0000, 32'sh4000_0000, 0, 0), 0);
        send_ray(unit_box_ray(32'sh0, -32'sh4000_0000, 0, 0), 0);
        // near-zero components: eps edges
        send_ray(unit_box_ray(32'sh0, 32'sd1073, 32'sd1074, 0), 0);
        send_ray(unit_box_ray(32'sh0, 32'sd1074, -32'sd1073, 0), 0);
        send_ray(unit_box_ray(32'sh0, -32'sd1074, 0, 32'sd1073), 2);
        // parallel rays: inside the box, then outside the y slab
        send_ray(unit_box_ray(32'sh0001_8000, 0, 0, 0), 0);
        r = unit_box_ray(32'sh0001_8000, 0, 0, 0);
        r.origin_y = 32'sh0002_0000;
        send_ray(r, 0);
        // y and z faces
        r = unit_box_ray(32'sh0001_8000, 0, 32'sh4000_0000, 0);
        r.origin_y = -32'sh0002_0000;
        send_ray(r, 0);
        r = unit_box_ray(32'sh0001_8000, 0, 0, -32'sh4000_0000);
        r.origin_z = 32'sh0005_0000;
        send_ray(r, 0);
        // saturation: far box, tiny direction
        r = unit_box_ray(32'sh8000_0000, 32'sd1074, 0, 0);
        r.box_min_x = 32'sh7FFF_0000; r.box_max_x = 32'sh7FFF_FFFF;
        send_ray(r, 0);
        r.dir_x = 32'sh7FFF_FFFF;
        send_ray(r, 0);
        r.dir_x = 32'sh8000_0000; r.origin_x = 32'sh7FFF_FFFF;
        r.box_min_x = 32'sh8000_0000; r.box_max_x = 32'sh8000_0001;
        send_ray(r, 0);
        // inverted box
        r = unit_box_ray(32'sh0, 32'sh4000_0000, 0, 0);
        r.box_min_x = 32'sh0002_0000; r.box_max_x = 32'sh0001_0000;
        send_ray(r, 3);
        // degenerate box, touching point
        r = unit_box_ray(32'sh0, 32'sh4000_0000, 0, 0);
        r.box_max_x = 32'sh0001_0000;
        send_ray(r, 0);
        // all-ones and all-zero words
        r = '1;
        send_ray(r, 0);
        r = '0;
        send_ray(r, 0);
        // diagonal
        send_ray(unit_box_ray(32'sh0, 32'sh2D41_3CCD, 32'sh2D41_3CCD, 0), 0);
    endtask

    task automatic test_random(int count);
        int scale;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 3))
                0: scale = 0;
                1: scale = 32'h0010_0000;
                default: scale = 32'h0004_0000;
            endcase
            // every fourth block of 64 runs back to back
            send_ray(make_ray(scale), ((k / 64) % 4 == 3) ? 0 : $urandom_range(0, 14));
        end
        start <= 1'b0;
    endtask

    task automatic drain();
        while (hits_pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1630);
        drain();
        $display("Sent %0d rays (%0d hits), checked %0d results.", n_sent, n_hits, n_checked);
        $display("Covered face entries, parallel slabs, saturation and inverted boxes.");
        if (n_errors == 0 && hits_pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
src/rbs_pkg.sv
src/rbs_axis_div.sv
src/ray_box_slab_intersection.sv
tb/ray_box_slab_intersection_tb.sv
